>>> sv/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg: shared constants and types
// Sizes, operation and result codes, and the sequencer state encoding.
// ----------------------------------------------------------------------------
package sbm_pkg;

  localparam int IMAGE_SIDE    = 80;
  localparam int TEMPLATE_SIDE = 8;
  localparam int POINT_OFFSET  = 4;

  localparam int PIXELS   = IMAGE_SIDE * IMAGE_SIDE;
  localparam int SEARCH_R = 4;
  localparam int SEARCH_N = 2 * SEARCH_R + 1;
  localparam int WEIGHTS  = SEARCH_N * SEARCH_N;

  localparam int PIX_AW  = $clog2(PIXELS);
  localparam int W_AW    = $clog2(WEIGHTS);
  localparam int T_W     = (TEMPLATE_SIDE > 2) ? $clog2(TEMPLATE_SIDE) : 1;
  localparam int COORD_W = 10;
  localparam int SAD_W   = $clog2(TEMPLATE_SIDE * TEMPLATE_SIDE * 65535 + 2);
  localparam int CNT_W   = 13;
  localparam int SUM_W   = 17;
  localparam int NUM_W   = SUM_W + 8;
  localparam int DIV_CW  = $clog2(NUM_W + 1);
  localparam int PRED_W  = 12;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam int PRED_LIM = 1024;

  typedef enum logic [2:0] {
    OP_WR_WEIGHT = 3'd0,
    OP_WR_PREV   = 3'd1,
    OP_WR_CUR    = 3'd2,
    OP_MATCH     = 3'd3,
    OP_FINISH    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_MATCH   = 2'd1,
    KIND_PREDICT = 2'd2
  } kind_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MATCH = 7'b0000010,
    S_DRAIN = 7'b0000100,
    S_VOTE  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_PRED  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  // tag that follows a pixel read through the SAD pipeline
  typedef struct packed {
    logic       first;
    logic       last_px;
    logic       final_win;
    logic       prev_oob;
    logic       cur_oob;
    logic [3:0] cr;
    logic [3:0] cc;
  } tag_t;

endpackage

>>> sv/sbm_in_if.sv
// ----------------------------------------------------------------------------
// sbm_in_if: request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface sbm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [12:0] address;
  logic [15:0] value;
  logic [5:0]  point_row;
  logic [5:0]  point_col;

  modport source(output valid, operation, address, value, point_row, point_col,
                 input ready);
  modport sink(input valid, operation, address, value, point_row, point_col,
               output ready);
endinterface

>>> sv/sbm_out_if.sv
// ----------------------------------------------------------------------------
// sbm_out_if: result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface sbm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [3:0]  disp_row;
  logic signed [3:0]  disp_col;
  logic [6:0]         match_row;
  logic [6:0]         match_col;
  logic signed [11:0] predict_row;
  logic signed [11:0] predict_col;
  logic [12:0]        vote_total;

  modport source(output valid, kind, disp_row, disp_col, match_row, match_col,
                 predict_row, predict_col, vote_total, input ready);
  modport sink(input valid, kind, disp_row, disp_col, match_row, match_col,
               predict_row, predict_col, vote_total, output ready);
endinterface

>>> sv/sbm_cfg_if.sv
// ----------------------------------------------------------------------------
// sbm_cfg_if: configuration write channel
// Valid/ready channel carrying the vote threshold.
// ----------------------------------------------------------------------------
interface sbm_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

>>> sv/sbm_ram.sv
// ----------------------------------------------------------------------------
// sbm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/sad_block_match_flow.sv
// ----------------------------------------------------------------------------
// sad_block_match_flow: SAD block-matching optical flow
// Frame and weight stores, windowed SAD search, vote tally and mean.
// ----------------------------------------------------------------------------
// Channels: in_ch takes request words (weight write, previous or current pixel
// write, match point, finish); out_ch returns exactly one result word per
// request; cfg_ch writes the vote threshold and is always ready.
// A write request is answered from the response state once the output register
// is free. A match reads one previous and one current pixel per cycle from the
// frame RAMs for each of the 81 candidate windows, then drains the SAD pipeline.
// A finish runs a 1-bit-per-cycle restoring divider when a prediction is made
// and goes straight to the response otherwise.
// One request is in work at a time; in_ch.ready is high only between requests.
// A finished result sits in the output register, so a new request is taken
// while it waits; if the receiver stalls a second result, the block holds it
// and stops taking requests until out_ch moves.
// Reset clears the vote count, displacement sums, threshold and control; the
// frames and weight table hold whatever was written and need no clearing.
// ----------------------------------------------------------------------------
module sad_block_match_flow
  import sbm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  sbm_in_if.sink       in_ch,
  sbm_out_if.source    out_ch,
  sbm_cfg_if.sink      cfg_ch
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]        thr_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [SUM_W-1:0] sum_r_r, sum_c_r;

  logic signed [COORD_W-1:0] r0_r, c0_r;
  logic [3:0]     sr_r, sc_r;
  logic [T_W-1:0] ti_r, tj_r;

  // ---- request accept and store writes
  logic in_acc;
  op_t  in_op;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_op       = op_t'(in_ch.operation);

  logic w_we, p_we, c_we;
  assign w_we = in_acc && in_op == OP_WR_WEIGHT && int'(in_ch.address) < WEIGHTS;
  assign p_we = in_acc && in_op == OP_WR_PREV && int'(in_ch.address) < PIXELS;
  assign c_we = in_acc && in_op == OP_WR_CUR && int'(in_ch.address) < PIXELS;

  assign cfg_ch.ready = 1'b1;

  // ---- scan address generation
  logic signed [COORD_W-1:0] p_row, p_col, q_row, q_col;
  logic [PIX_AW-1:0] p_addr, q_addr;
  logic [W_AW-1:0]   w_addr;
  logic p_oob, q_oob, tj_last, ti_last, sc_last, sr_last;
  tag_t s0_tag;

  always_comb begin
    p_row = COORD_W'(int'(r0_r) + int'(ti_r));
    p_col = COORD_W'(int'(c0_r) + int'(tj_r));
    q_row = COORD_W'(int'(p_row) + int'(sr_r) - SEARCH_R);
    q_col = COORD_W'(int'(p_col) + int'(sc_r) - SEARCH_R);
    p_oob = p_row < 0 || p_col < 0 || int'(p_row) >= IMAGE_SIDE
            || int'(p_col) >= IMAGE_SIDE;
    q_oob = q_row < 0 || q_col < 0 || int'(q_row) >= IMAGE_SIDE
            || int'(q_col) >= IMAGE_SIDE;
    p_addr = PIX_AW'(int'(p_row) * IMAGE_SIDE + int'(p_col));
    q_addr = PIX_AW'(int'(q_row) * IMAGE_SIDE + int'(q_col));
    w_addr = W_AW'(int'(sr_r) * SEARCH_N + int'(sc_r));
    tj_last = tj_r == T_W'(TEMPLATE_SIDE - 1);
    ti_last = ti_r == T_W'(TEMPLATE_SIDE - 1);
    sc_last = int'(sc_r) == SEARCH_N - 1;
    sr_last = int'(sr_r) == SEARCH_N - 1;
    s0_tag.first     = ti_r == '0 && tj_r == '0;
    s0_tag.last_px   = ti_last && tj_last;
    s0_tag.final_win = ti_last && tj_last && sc_last && sr_last;
    s0_tag.prev_oob  = p_oob;
    s0_tag.cur_oob   = q_oob;
    s0_tag.cr        = sr_r;
    s0_tag.cc        = sc_r;
  end

  logic [15:0] p_rd, q_rd, w_rd;

  sbm_ram #(.WIDTH(16), .DEPTH(PIXELS)) u_prev (
    .clk(clk), .we(p_we), .waddr(in_ch.address[PIX_AW-1:0]),
    .wdata(in_ch.value), .raddr(p_addr), .rdata(p_rd));

  sbm_ram #(.WIDTH(16), .DEPTH(PIXELS)) u_cur (
    .clk(clk), .we(c_we), .waddr(in_ch.address[PIX_AW-1:0]),
    .wdata(in_ch.value), .raddr(q_addr), .rdata(q_rd));

  sbm_ram #(.WIDTH(16), .DEPTH(WEIGHTS)) u_wgt (
    .clk(clk), .we(w_we), .waddr(in_ch.address[W_AW-1:0]),
    .wdata(in_ch.value), .raddr(w_addr), .rdata(w_rd));

  // ---- SAD pipeline: s1 accumulate, s2 weight multiply, s3 compare
  logic s1_v_r, s2_v_r, s3_v_r;
  tag_t s1_tag_r, s2_tag_r, s3_tag_r;
  logic [SAD_W-1:0] acc_r, s2_sad_r;
  logic [15:0]      s2_w_r;
  logic [31:0]      prod_r, best_r;
  logic [3:0]       best_ri_r, best_ci_r;

  logic [15:0]      pa, pb, diff;
  logic [SAD_W-1:0] acc_sum;
  always_comb begin
    pa      = s1_tag_r.prev_oob ? 16'd0 : p_rd;
    pb      = s1_tag_r.cur_oob ? 16'd0 : q_rd;
    diff    = (pa > pb) ? pa - pb : pb - pa;
    acc_sum = (s1_tag_r.first ? '0 : acc_r) + SAD_W'(diff);
  end

  // ---- divider
  logic [NUM_W-1:0]  num_r_r, num_c_r, quo_r_r, quo_c_r;
  logic [CNT_W:0]    rem_r_r, rem_c_r;
  logic [CNT_W-1:0]  den_r;
  logic              neg_r_r, neg_c_r;
  logic [DIV_CW-1:0] div_cnt_r;

  logic [CNT_W:0] rx_r, rx_c;
  logic           ge_r, ge_c;
  always_comb begin
    rx_r = {rem_r_r[CNT_W-1:0], num_r_r[NUM_W-1]};
    rx_c = {rem_c_r[CNT_W-1:0], num_c_r[NUM_W-1]};
    ge_r = rx_r >= {1'b0, den_r};
    ge_c = rx_c >= {1'b0, den_r};
  end

  function automatic logic [PRED_W-1:0] clamp_q(logic [NUM_W-1:0] q, logic neg);
    logic [PRED_W-1:0] m;
    m = (int'(q) > PRED_LIM) ? PRED_W'(PRED_LIM) : q[PRED_W-1:0];
    return neg ? -m : m;
  endfunction

  function automatic logic [SUM_W-1:0] mag(logic signed [SUM_W-1:0] s);
    return s[SUM_W-1] ? -s : s;
  endfunction

  // ---- vote decision
  logic voted;
  logic [CNT_W-1:0] cnt_after;
  assign voted = !(int'(best_ri_r) == SEARCH_R && int'(best_ci_r) == SEARCH_R)
                 && cnt_r < COUNT_MAX;
  assign cnt_after = voted ? cnt_r + 1'b1 : cnt_r;

  // ---- pending result
  kind_t res_kind_r;
  logic [3:0]        res_dr_r, res_dc_r;
  logic [6:0]        res_mr_r, res_mc_r;
  logic [PRED_W-1:0] res_pr_r, res_pc_r;
  logic [CNT_W-1:0]  res_vt_r;
  logic              out_v_r;
  logic              out_free;
  assign out_free = !out_v_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_MATCH) begin
            state_nxt = S_MATCH;
          end else if (in_op == OP_FINISH && cnt_r != '0 && cnt_r >= thr_r) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_MATCH: if (s0_tag.final_win) state_nxt = S_DRAIN;
      S_DRAIN: if (s3_v_r && s3_tag_r.final_win) state_nxt = S_VOTE;
      S_VOTE:  state_nxt = S_RESP;
      S_DIV:   if (int'(div_cnt_r) == 1) state_nxt = S_PRED;
      S_PRED:  state_nxt = S_RESP;
      S_RESP:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      thr_r   <= '0;
      cnt_r   <= '0;
      sum_r_r <= '0;
      sum_c_r <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        thr_r <= cfg_ch.data;
      end
      s1_v_r <= state_r == S_MATCH;
      s2_v_r <= s1_v_r && s1_tag_r.last_px;
      s3_v_r <= s2_v_r;
      if (in_acc && in_op == OP_FINISH) begin
        cnt_r   <= '0;
        sum_r_r <= '0;
        sum_c_r <= '0;
      end else if (state_r == S_VOTE && voted) begin
        cnt_r   <= cnt_after;
        sum_r_r <= sum_r_r + SUM_W'(int'(best_ri_r) - SEARCH_R);
        sum_c_r <= sum_c_r + SUM_W'(int'(best_ci_r) - SEARCH_R);
      end
      if (state_r == S_RESP && out_free) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    s1_tag_r <= s0_tag;
    if (in_acc) begin
      r0_r <= COORD_W'(int'(in_ch.point_row) + POINT_OFFSET);
      c0_r <= COORD_W'(int'(in_ch.point_col) + POINT_OFFSET);
      sr_r <= '0;
      sc_r <= '0;
      ti_r <= '0;
      tj_r <= '0;
      best_r    <= '1;
      best_ri_r <= '0;
      best_ci_r <= '0;
      res_kind_r <= KIND_ACK;
      res_dr_r <= '0;
      res_dc_r <= '0;
      res_mr_r <= '0;
      res_mc_r <= '0;
      res_pr_r <= '0;
      res_pc_r <= '0;
      res_vt_r <= '0;
      if (in_op == OP_FINISH) begin
        res_kind_r <= KIND_PREDICT;
        res_vt_r   <= cnt_r;
        den_r      <= cnt_r;
        neg_r_r    <= sum_r_r[SUM_W-1];
        neg_c_r    <= sum_c_r[SUM_W-1];
        num_r_r    <= {mag(sum_r_r), 8'd0};
        num_c_r    <= {mag(sum_c_r), 8'd0};
        rem_r_r    <= '0;
        rem_c_r    <= '0;
        div_cnt_r  <= DIV_CW'(NUM_W);
      end
    end
    // advance the scan: column, row, then candidate
    if (state_r == S_MATCH) begin
      tj_r <= tj_last ? '0 : tj_r + 1'b1;
      if (tj_last) begin
        ti_r <= ti_last ? '0 : ti_r + 1'b1;
        if (ti_last) begin
          sc_r <= sc_last ? '0 : sc_r + 1'b1;
          if (sc_last) begin
            sr_r <= sr_r + 1'b1;
          end
        end
      end
    end
    if (s1_v_r) begin
      acc_r <= acc_sum;
      if (s1_tag_r.last_px) begin
        s2_sad_r <= acc_sum + 1'b1;
        s2_w_r   <= w_rd;
        s2_tag_r <= s1_tag_r;
      end
    end
    if (s2_v_r) begin
      prod_r   <= 32'(s2_sad_r * s2_w_r);
      s3_tag_r <= s2_tag_r;
    end
    // first strict minimum wins
    if (s3_v_r && prod_r < best_r) begin
      best_r    <= prod_r;
      best_ri_r <= s3_tag_r.cr;
      best_ci_r <= s3_tag_r.cc;
    end
    if (state_r == S_VOTE) begin
      res_kind_r <= KIND_MATCH;
      res_dr_r <= 4'(int'(best_ri_r) - SEARCH_R);
      res_dc_r <= 4'(int'(best_ci_r) - SEARCH_R);
      res_mr_r <= 7'(int'(r0_r) + int'(best_ri_r) - SEARCH_R);
      res_mc_r <= 7'(int'(c0_r) + int'(best_ci_r) - SEARCH_R);
      res_vt_r <= cnt_after;
    end
    if (state_r == S_DIV) begin
      rem_r_r   <= ge_r ? rx_r - {1'b0, den_r} : rx_r;
      rem_c_r   <= ge_c ? rx_c - {1'b0, den_r} : rx_c;
      quo_r_r   <= {quo_r_r[NUM_W-2:0], ge_r};
      quo_c_r   <= {quo_c_r[NUM_W-2:0], ge_c};
      num_r_r   <= {num_r_r[NUM_W-2:0], 1'b0};
      num_c_r   <= {num_c_r[NUM_W-2:0], 1'b0};
      div_cnt_r <= div_cnt_r - 1'b1;
    end
    if (state_r == S_PRED) begin
      res_pr_r <= clamp_q(quo_r_r, neg_r_r);
      res_pc_r <= clamp_q(quo_c_r, neg_c_r);
    end
    if (state_r == S_RESP && out_free) begin
      out_ch.kind        <= res_kind_r;
      out_ch.disp_row    <= res_dr_r;
      out_ch.disp_col    <= res_dc_r;
      out_ch.match_row   <= res_mr_r;
      out_ch.match_col   <= res_mc_r;
      out_ch.predict_row <= res_pr_r;
      out_ch.predict_col <= res_pc_r;
      out_ch.vote_total  <= res_vt_r;
    end
  end

  assign out_ch.valid = out_v_r;

  // ---- checks
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MATCH || state_r == S_DRAIN) |-> !(p_we || c_we || w_we))
    else $error("frame write during scan");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> (state_r == S_MATCH || state_r == S_DRAIN))
    else $error("compare stage active outside scan");

  a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_free) |=> out_v_r)
    else $error("result not presented");

  a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> (div_cnt_r != '0 && den_r != '0))
    else $error("divider ran past its steps");

endmodule
